// ===== rtl/core/atrlm_pkg.sv =====
`default_nettype none

package atrlm_pkg;

  // Line buffer capacity and expected token size
  localparam int LINE_CAP    = 256;
  localparam int TOKEN_CHARS = 8;
  localparam int COUNT_W     = $clog2(LINE_CAP);

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [1:0]         kind_t;
  typedef logic [2:0]         outcome_t;
  typedef logic [1:0]         reg_index_t;
  typedef logic [1:0]         track_t;

  // Request kinds
  localparam kind_t KIND_BYTE  = 2'd0;
  localparam kind_t KIND_TICK  = 2'd1;
  localparam kind_t KIND_START = 2'd2;

  // Result outcomes
  localparam outcome_t OUTCOME_OK      = 3'd0;
  localparam outcome_t OUTCOME_BUSY    = 3'd1;
  localparam outcome_t OUTCOME_FAIL    = 3'd2;
  localparam outcome_t OUTCOME_ERROR   = 3'd3;
  localparam outcome_t OUTCOME_TIMEOUT = 3'd4;
  localparam outcome_t OUTCOME_UNSOL   = 3'd5;

  // Configuration register indexes
  localparam reg_index_t REG_TOKEN     = 2'd0;
  localparam reg_index_t REG_TOKEN_LEN = 2'd1;
  localparam reg_index_t REG_WINDOW    = 2'd2;
  localparam reg_index_t REG_UNSOL     = 2'd3;

  // Configuration defaults
  localparam logic [63:0] TOKEN_RESET     = 64'h0000_0000_0000_4F4B;
  localparam logic [3:0]  TOKEN_LEN_RESET = 4'd2;
  localparam logic [9:0]  WINDOW_RESET    = 10'd50;

  // Characters and search patterns
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_LF    = 8'h0A;
  localparam logic [7:0]  CHAR_O     = 8'h4F;
  localparam logic [7:0]  CHAR_K     = 8'h4B;
  localparam logic [31:0] PAT_BUSY   = 32'h6275_7379;
  localparam logic [31:0] PAT_FAIL   = 32'h4641_494C;
  localparam logic [39:0] PAT_ERROR  = 40'h45_5252_4F52;

  // Saturation limits
  localparam logic [19:0] ELAPSED_MAX = 20'hF_FFFF;
  localparam logic [9:0]  WINDOW_MAX  = 10'h3FF;

  // Exact "OK" line tracker codes
  localparam track_t TRACK_EMPTY = 2'd0;
  localparam track_t TRACK_O     = 2'd1;
  localparam track_t TRACK_OK    = 2'd2;
  localparam track_t TRACK_OTHER = 2'd3;

  // Found flag bit positions
  localparam int FLAG_BUSY  = 0;
  localparam int FLAG_FAIL  = 1;
  localparam int FLAG_ERROR = 2;
  localparam int FLAG_TOKEN = 3;

endpackage

`default_nettype wire

// ===== rtl/core/atrlm_item_if.sv =====
`default_nettype none

interface atrlm_item_if import atrlm_pkg::*; ();
  logic        valid;
  logic        ready;
  kind_t       kind;
  logic [7:0]  data_byte;
  logic [19:0] cmd_timeout;

  modport source (output valid, kind, data_byte, cmd_timeout, input ready);
  modport sink   (input valid, kind, data_byte, cmd_timeout, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/atrlm_result_if.sv =====
`default_nettype none

interface atrlm_result_if import atrlm_pkg::*; ();
  logic       valid;
  logic       ready;
  outcome_t   outcome;
  logic [7:0] line_length;

  modport source (output valid, outcome, line_length, input ready);
  modport sink   (input valid, outcome, line_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/atrlm_cfg_if.sv =====
`default_nettype none

interface atrlm_cfg_if import atrlm_pkg::*; ();
  logic        valid;
  logic        ready;
  reg_index_t  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/at_response_line_matcher_core.sv =====
// Channel  Dir  Payload                          Accepted when
// item     in   kind, data_byte, cmd_timeout     item.valid && item.ready
// result   out  outcome, line_length             result.valid && result.ready
// cfg      in   index, data                      cfg.valid (cfg.ready is always high)
//
// One request per cycle: state is updated in a single registered step.
// A result sits in a one-entry output register; item.ready drops only while
// that register is full and result.ready is low.
// rst is synchronous: configuration returns to its defaults ("OK", 2, 50, 0)
// and the block comes up disarmed with an empty line.
`default_nettype none

module at_response_line_matcher_core import atrlm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  atrlm_item_if.sink     item,
  atrlm_result_if.source result,
  atrlm_cfg_if.sink      cfg
);

  // Configuration registers
  logic [63:0] expected_token;
  logic [3:0]  token_length;
  logic [9:0]  line_window_ms;
  logic        report_unsolicited;

  // Command and line state
  logic        armed, armed_next;
  logic [19:0] elapsed_ms, elapsed_ms_next;
  logic [9:0]  window_ms, window_ms_next;
  count_t      char_count, char_count_next;
  logic [63:0] recent_chars, recent_chars_next;
  logic [3:0]  found_flags, found_flags_next;
  track_t      exact_ok_track, exact_ok_track_next;
  logic [19:0] limit_ms, limit_ms_next;

  // Output register
  logic        res_valid;
  outcome_t    res_outcome;
  logic [7:0]  res_length;
  logic        result_fire;
  outcome_t    result_outcome_next;
  logic [7:0]  result_length_next;

  logic        accept;
  logic [9:0]  window_eff;
  logic [9:0]  window_inc;
  logic [19:0] elapsed_inc;

  // Character intake
  count_t      count_inc;
  logic [63:0] recent_shift;
  logic [3:0]  token_eff;
  logic [TOKEN_CHARS-1:0] byte_ok;
  logic        token_hit;
  logic [3:0]  flags_take;
  track_t      track_take;

  // Line close decision
  logic        close_hit;
  logic        close_emit;
  outcome_t    close_outcome;

  assign accept     = item.valid && item.ready;
  assign item.ready = !res_valid || result.ready;
  assign cfg.ready  = 1'b1;

  assign result.valid       = res_valid;
  assign result.outcome     = res_outcome;
  assign result.line_length = res_length;

  assign window_eff  = (line_window_ms == '0) ? 10'd1 : line_window_ms;
  assign window_inc  = (window_ms < WINDOW_MAX) ? window_ms + 10'd1 : window_ms;
  assign elapsed_inc = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 20'd1 : elapsed_ms;

  // Shift the new character in and search the stream
  assign count_inc    = char_count + count_t'(1);
  assign recent_shift = {recent_chars[55:0], item.data_byte};
  assign token_eff    = (token_length > 4'(TOKEN_CHARS)) ? 4'(TOKEN_CHARS) : token_length;

  always_comb begin
    for (int i = 0; i < TOKEN_CHARS; i++) begin
      byte_ok[i] = (4'(i) >= token_eff) ||
                   (recent_shift[8*i +: 8] == expected_token[8*i +: 8]);
    end
  end

  assign token_hit = (token_eff == 4'd0) ||
                     ((count_inc >= COUNT_W'(token_eff)) && (&byte_ok));

  always_comb begin
    flags_take = found_flags;
    if (count_inc >= COUNT_W'(4) && recent_shift[31:0] == PAT_BUSY) begin
      flags_take[FLAG_BUSY] = 1'b1;
    end
    if (count_inc >= COUNT_W'(4) && recent_shift[31:0] == PAT_FAIL) begin
      flags_take[FLAG_FAIL] = 1'b1;
    end
    if (count_inc >= COUNT_W'(5) && recent_shift[39:0] == PAT_ERROR) begin
      flags_take[FLAG_ERROR] = 1'b1;
    end
    if (token_hit) begin
      flags_take[FLAG_TOKEN] = 1'b1;
    end
  end

  always_comb begin
    case (exact_ok_track)
      TRACK_EMPTY: track_take = (item.data_byte == CHAR_O) ? TRACK_O : TRACK_OTHER;
      TRACK_O:     track_take = (item.data_byte == CHAR_K) ? TRACK_OK : TRACK_OTHER;
      default:     track_take = TRACK_OTHER;
    endcase
  end

  // Pick the close outcome by priority
  assign close_hit  = |found_flags;
  assign close_emit = close_hit || (report_unsolicited && exact_ok_track != TRACK_OK);

  always_comb begin
    if (found_flags[FLAG_BUSY]) begin
      close_outcome = OUTCOME_BUSY;
    end else if (found_flags[FLAG_FAIL]) begin
      close_outcome = OUTCOME_FAIL;
    end else if (found_flags[FLAG_ERROR]) begin
      close_outcome = OUTCOME_ERROR;
    end else if (found_flags[FLAG_TOKEN]) begin
      close_outcome = OUTCOME_OK;
    end else begin
      close_outcome = OUTCOME_UNSOL;
    end
  end

  // Next state for one request
  always_comb begin
    armed_next          = armed;
    elapsed_ms_next     = elapsed_ms;
    window_ms_next      = window_ms;
    char_count_next     = char_count;
    recent_chars_next   = recent_chars;
    found_flags_next    = found_flags;
    exact_ok_track_next = exact_ok_track;
    limit_ms_next       = limit_ms;
    result_fire         = 1'b0;
    result_outcome_next = OUTCOME_TIMEOUT;
    result_length_next  = '0;

    if (accept) begin
      case (item.kind)
        KIND_START: begin
          armed_next          = 1'b1;
          elapsed_ms_next     = '0;
          limit_ms_next       = item.cmd_timeout;
          char_count_next     = '0;
          recent_chars_next   = '0;
          found_flags_next    = '0;
          exact_ok_track_next = TRACK_EMPTY;
          window_ms_next      = '0;
          if (item.cmd_timeout == '0) begin
            armed_next  = 1'b0;
            result_fire = 1'b1;
          end
        end

        KIND_BYTE: begin
          if (armed && item.data_byte != CHAR_CR) begin
            if ((item.data_byte == CHAR_LF && char_count != '0) ||
                (item.data_byte != CHAR_LF && char_count == count_t'(LINE_CAP - 1))) begin
              // Close the line; a character at the cap is dropped
              result_fire         = close_emit;
              result_outcome_next = close_outcome;
              result_length_next  = 8'(char_count);
              if (close_hit) begin
                armed_next = 1'b0;
              end
              char_count_next     = '0;
              recent_chars_next   = '0;
              found_flags_next    = '0;
              exact_ok_track_next = TRACK_EMPTY;
              window_ms_next      = '0;
            end else if (item.data_byte != CHAR_LF) begin
              char_count_next     = count_inc;
              recent_chars_next   = recent_shift;
              found_flags_next    = flags_take;
              exact_ok_track_next = track_take;
            end
          end
        end

        KIND_TICK: begin
          if (armed) begin
            elapsed_ms_next = elapsed_inc;
            window_ms_next  = window_inc;
            if (char_count != '0 && window_inc >= window_eff) begin
              // Window ran out with characters held: close the line
              result_fire         = close_emit;
              result_outcome_next = close_outcome;
              result_length_next  = 8'(char_count);
              if (close_hit) begin
                armed_next = 1'b0;
              end
              char_count_next     = '0;
              recent_chars_next   = '0;
              found_flags_next    = '0;
              exact_ok_track_next = TRACK_EMPTY;
              window_ms_next      = '0;
            end else if (char_count == '0 && window_inc >= window_eff) begin
              window_ms_next = '0;
            end

            // Check the overall timeout when nothing came out and either no line is pending or its window ran out
            if (!result_fire && (char_count == '0 || window_inc >= window_eff) &&
                elapsed_inc >= limit_ms) begin
              armed_next          = 1'b0;
              char_count_next     = '0;
              recent_chars_next   = '0;
              found_flags_next    = '0;
              exact_ok_track_next = TRACK_EMPTY;
              window_ms_next      = '0;
              result_fire         = 1'b1;
              result_outcome_next = OUTCOME_TIMEOUT;
              result_length_next  = '0;
            end
          end
        end

        default: begin
        end
      endcase
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_token     <= TOKEN_RESET;
      token_length       <= TOKEN_LEN_RESET;
      line_window_ms     <= WINDOW_RESET;
      report_unsolicited <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TOKEN:     expected_token     <= cfg.data;
        REG_TOKEN_LEN: token_length       <= cfg.data[3:0];
        REG_WINDOW:    line_window_ms     <= cfg.data[9:0];
        REG_UNSOL:     report_unsolicited <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // Advance command and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      armed          <= 1'b0;
      elapsed_ms     <= '0;
      window_ms      <= '0;
      char_count     <= '0;
      recent_chars   <= '0;
      found_flags    <= '0;
      exact_ok_track <= TRACK_EMPTY;
      limit_ms       <= '0;
    end else begin
      armed          <= armed_next;
      elapsed_ms     <= elapsed_ms_next;
      window_ms      <= window_ms_next;
      char_count     <= char_count_next;
      recent_chars   <= recent_chars_next;
      found_flags    <= found_flags_next;
      exact_ok_track <= exact_ok_track_next;
      limit_ms       <= limit_ms_next;
    end
  end

  // Hold a result until taken; load a new one on the same edge it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (result_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      res_outcome <= result_outcome_next;
      res_length  <= result_length_next;
    end
  end

`ifndef ASSERT_OFF
  a_timeout_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_outcome == OUTCOME_TIMEOUT |-> res_length == '0)
    else $error("timeout result carries a nonzero line length");

  a_end_disarms: assert property (@(posedge clk) disable iff (rst)
    result_fire && result_outcome_next != OUTCOME_UNSOL |=> !armed)
    else $error("command-ending result left the block armed");

  a_idle_line_empty: assert property (@(posedge clk) disable iff (rst)
    !armed |-> char_count == '0 && found_flags == '0)
    else $error("line state held while disarmed");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    !res_valid ##1 res_valid |-> $past(accept))
    else $error("result appeared without an accepted request");
`endif

endmodule

`default_nettype wire
